// File: design/command_line_tokenizer_top_defines.svh
// Assertion macros shared by the command line tokenizer RTL.
// Included by command_line_tokenizer_top; needs a clock and reset in scope.
`ifndef COMMAND_LINE_TOKENIZER_TOP_DEFINES_SVH
`define COMMAND_LINE_TOKENIZER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CLT_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tokenizer assertion failed");

// Next-cycle implication, checked outside reset.
`define CLT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tokenizer assertion failed");

`endif

// File: design/clt_pkg.sv
// Shared types, character codes and limits of the command line tokenizer.
// Used by clt_core, clt_rsp_fifo and command_line_tokenizer_top; no dependencies.
package clt_pkg;

   localparam int MAX_COMMANDS_DEF  = 4;
   localparam int MAX_ARGUMENTS_DEF = 16;
   localparam int LINE_LENGTH_DEF   = 256;

   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   localparam logic [7:0] CHAR_NUL    = 8'h00;
   localparam logic [7:0] CHAR_QUOTE  = 8'h22;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_SEMI   = 8'h3B;
   localparam logic [7:0] CHAR_BSLASH = 8'h5C;

   typedef enum logic [1:0] {
      KIND_BEGIN,
      KIND_CHAR,
      KIND_DONE
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK,
      STATUS_SYNTAX,
      STATUS_TRUNCATED
   } status_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] ch;
      logic [1:0] cmd;
      logic [3:0] arg;
      status_type status;
      logic [2:0] total;
      logic       last;
   } rsp_type;

   // Results produced by one accepted character, in delivery order.
   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } push_type;

   function automatic rsp_type mk_rsp(kind_type kind, logic [7:0] ch, logic [1:0] cmd,
                                      logic [3:0] arg, status_type status,
                                      logic [2:0] total);
      rsp_type r;
      r.kind   = kind;
      r.ch     = ch;
      r.cmd    = cmd;
      r.arg    = arg;
      r.status = status;
      r.total  = total;
      r.last   = 1'b0;
      return r;
   endfunction

endpackage

// File: design/clt_core.sv
// Tokenizer state registers and the per-character next-state and result logic.
// Depends on clt_pkg; produces up to two results per accepted character.
module clt_core
   import clt_pkg::*;
#(
   parameter int MAX_COMMANDS  = MAX_COMMANDS_DEF,
   parameter int MAX_ARGUMENTS = MAX_ARGUMENTS_DEF,
   parameter int LINE_LENGTH   = LINE_LENGTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] char_code,
   output push_type   push
);

   localparam int CW = $clog2(MAX_COMMANDS + 1);
   localparam int AW = $clog2(MAX_ARGUMENTS + 1);
   localparam int PW = $clog2(LINE_LENGTH);

   logic          inarg_ff, inarg_in;
   logic          quote_ff, quote_in;
   logic          bs_ff, bs_in;
   logic [CW-1:0] cmd_ff, cmd_in;
   logic [AW-1:0] argc_ff, argc_in;
   logic [PW-1:0] pos_ff, pos_in;
   logic          lim_ff, lim_in;
   logic          bad_ff, bad_in;

   rsp_type       res_c [2];
   logic [1:0]    n_c;
   logic          esc_done;
   logic [CW:0]   total_wide;
   status_type    status_c;

   always_comb begin
      inarg_in   = inarg_ff;
      quote_in   = quote_ff;
      bs_in      = bs_ff;
      cmd_in     = cmd_ff;
      argc_in    = argc_ff;
      pos_in     = pos_ff;
      lim_in     = lim_ff;
      bad_in     = bad_ff;
      res_c[0]   = '0;
      res_c[1]   = '0;
      n_c        = 2'd0;
      esc_done   = 1'b0;
      total_wide = {1'b0, cmd_ff} + (CW+1)'(argc_ff != '0);
      if (lim_ff) begin
         status_c = STATUS_TRUNCATED;
      end else if (bad_ff || quote_ff) begin
         status_c = STATUS_SYNTAX;
      end else begin
         status_c = STATUS_OK;
      end

      if (accept) begin
         if (char_code == CHAR_NUL) begin
            if (!lim_ff && !bad_ff && bs_ff) begin
               res_c[n_c[0]] = mk_rsp(KIND_CHAR, CHAR_BSLASH, 2'(cmd_ff),
                                      4'(argc_ff - 1'b1), STATUS_OK, 3'd0);
               n_c = n_c + 2'd1;
            end
            res_c[n_c[0]] = mk_rsp(KIND_DONE, 8'd0, 2'd0, 4'd0, status_c,
                                   3'(total_wide));
            n_c      = n_c + 2'd1;
            inarg_in = 1'b0;
            quote_in = 1'b0;
            bs_in    = 1'b0;
            cmd_in   = '0;
            argc_in  = '0;
            pos_in   = '0;
            lim_in   = 1'b0;
            bad_in   = 1'b0;
         end else if (!lim_ff && !bad_ff) begin
            if (pos_ff >= PW'(LINE_LENGTH - 1)) begin
               lim_in = 1'b1;
               bs_in  = 1'b0;
            end else begin
               pos_in = pos_ff + 1'b1;
               if (bs_ff) begin
                  bs_in = 1'b0;
                  if (char_code inside {CHAR_QUOTE, CHAR_SPACE, CHAR_SEMI}) begin
                     res_c[n_c[0]] = mk_rsp(KIND_CHAR, char_code, 2'(cmd_ff),
                                            4'(argc_ff - 1'b1), STATUS_OK, 3'd0);
                     n_c      = n_c + 2'd1;
                     esc_done = 1'b1;
                  end else begin
                     res_c[n_c[0]] = mk_rsp(KIND_CHAR, CHAR_BSLASH, 2'(cmd_ff),
                                            4'(argc_ff - 1'b1), STATUS_OK, 3'd0);
                     n_c = n_c + 2'd1;
                  end
               end
               if (!esc_done) begin
                  if (!inarg_ff) begin
                     if (char_code == CHAR_SEMI) begin
                        if (argc_ff != '0) begin
                           cmd_in  = cmd_ff + 1'b1;
                           argc_in = '0;
                        end
                     end else if (char_code != CHAR_SPACE) begin
                        if (cmd_ff >= CW'(MAX_COMMANDS) ||
                            argc_ff >= AW'(MAX_ARGUMENTS)) begin
                           lim_in = 1'b1;
                        end else begin
                           argc_in  = argc_ff + 1'b1;
                           inarg_in = 1'b1;
                           res_c[n_c[0]] = mk_rsp(KIND_BEGIN, 8'd0, 2'(cmd_ff),
                                                  4'(argc_ff), STATUS_OK, 3'd0);
                           n_c = n_c + 2'd1;
                           if (char_code == CHAR_QUOTE) begin
                              quote_in = 1'b1;
                           end else if (char_code == CHAR_BSLASH) begin
                              bs_in = 1'b1;
                           end else begin
                              res_c[n_c[0]] = mk_rsp(KIND_CHAR, char_code, 2'(cmd_ff),
                                                     4'(argc_ff), STATUS_OK, 3'd0);
                              n_c = n_c + 2'd1;
                           end
                        end
                     end
                  end else begin
                     case (char_code)
                        CHAR_BSLASH: begin
                           bs_in = 1'b1;
                        end
                        CHAR_QUOTE: begin
                           if (quote_ff) begin
                              quote_in = 1'b0;
                              inarg_in = 1'b0;
                           end else begin
                              res_c[n_c[0]] = mk_rsp(KIND_CHAR, char_code, 2'(cmd_ff),
                                                     4'(argc_ff - 1'b1), STATUS_OK, 3'd0);
                              n_c = n_c + 2'd1;
                           end
                        end
                        CHAR_SPACE: begin
                           if (quote_ff) begin
                              res_c[n_c[0]] = mk_rsp(KIND_CHAR, char_code, 2'(cmd_ff),
                                                     4'(argc_ff - 1'b1), STATUS_OK, 3'd0);
                              n_c = n_c + 2'd1;
                           end else begin
                              inarg_in = 1'b0;
                           end
                        end
                        CHAR_SEMI: begin
                           if (quote_ff) begin
                              bad_in = 1'b1;
                           end else begin
                              inarg_in = 1'b0;
                              if (argc_ff != '0) begin
                                 cmd_in  = cmd_ff + 1'b1;
                                 argc_in = '0;
                              end
                           end
                        end
                        default: begin
                           res_c[n_c[0]] = mk_rsp(KIND_CHAR, char_code, 2'(cmd_ff),
                                                  4'(argc_ff - 1'b1), STATUS_OK, 3'd0);
                           n_c = n_c + 2'd1;
                        end
                     endcase
                  end
               end
            end
         end
      end

      if (n_c == 2'd1) begin
         res_c[0].last = 1'b1;
      end else if (n_c == 2'd2) begin
         res_c[1].last = 1'b1;
      end
   end

   always_comb begin
      push.count  = n_c;
      push.first  = res_c[0];
      push.second = res_c[1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inarg_ff <= 1'b0;
         quote_ff <= 1'b0;
         bs_ff    <= 1'b0;
         cmd_ff   <= '0;
         argc_ff  <= '0;
         pos_ff   <= '0;
         lim_ff   <= 1'b0;
         bad_ff   <= 1'b0;
      end else begin
         inarg_ff <= inarg_in;
         quote_ff <= quote_in;
         bs_ff    <= bs_in;
         cmd_ff   <= cmd_in;
         argc_ff  <= argc_in;
         pos_ff   <= pos_in;
         lim_ff   <= lim_in;
         bad_ff   <= bad_in;
      end
   end

endmodule

// File: design/clt_rsp_fifo.sv
// Result queue: takes up to two results per cycle and delivers one per transaction.
// Depends on clt_pkg for the result type and the queue depth.
module clt_rsp_fifo
   import clt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  push_type push,
   input  logic    pop,
   output logic    full_for_two,
   output logic    rsp_valid,
   output rsp_type head
);

   rsp_type              mem_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0] wr_ff, wr_in;
   logic [RSP_PTR_W-1:0] rd_ff, rd_in;
   logic [RSP_CNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      wr_in  = wr_ff + RSP_PTR_W'(push.count);
      rd_in  = rd_ff + RSP_PTR_W'(pop);
      cnt_in = cnt_ff + RSP_CNT_W'(push.count) - RSP_CNT_W'(pop);
   end

   assign rsp_valid    = (cnt_ff != '0);
   assign full_for_two = (cnt_ff > RSP_CNT_W'(RSP_DEPTH - 2));
   assign head         = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_ff + 1'b1] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// File: design/command_line_tokenizer_top.sv
// Top level of the command line tokenizer: tokenizer core plus result queue.
// Depends on clt_pkg, clt_core, clt_rsp_fifo and command_line_tokenizer_top_defines.svh.
//
// One line character is taken per transaction, and a new character can be taken in
// every cycle in which req_stall is low. Each character yields zero, one or two
// results, written at once into a four-entry result queue; the result port delivers
// one result per cycle while rsp_stall is low, so characters that produce two results
// are taken no faster than the result port drains them. The request side stalls
// whenever the queue holds more than two results, which leaves room for the worst
// case of the next character.
`include "command_line_tokenizer_top_defines.svh"

module command_line_tokenizer_top
   import clt_pkg::*;
#(
   parameter int MAX_COMMANDS  = MAX_COMMANDS_DEF,
   parameter int MAX_ARGUMENTS = MAX_ARGUMENTS_DEF,
   parameter int LINE_LENGTH   = LINE_LENGTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_char_code,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_event_kind,
   output logic [7:0] rsp_char_value,
   output logic [1:0] rsp_command_number,
   output logic [3:0] rsp_argument_number,
   output logic [1:0] rsp_line_status,
   output logic [2:0] rsp_command_total,
   output logic       rsp_last_of_run
);

   logic     req_accept;
   logic     rsp_accept;
   push_type push;
   rsp_type  head;

   assign req_accept = req_valid && !req_stall;
   assign rsp_accept = rsp_valid && !rsp_stall;

   clt_core #(
      .MAX_COMMANDS  (MAX_COMMANDS),
      .MAX_ARGUMENTS (MAX_ARGUMENTS),
      .LINE_LENGTH   (LINE_LENGTH)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .char_code (req_char_code),
      .push      (push)
   );

   clt_rsp_fifo u_fifo (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .pop          (rsp_accept),
      .full_for_two (req_stall),
      .rsp_valid    (rsp_valid),
      .head         (head)
   );

   assign rsp_event_kind      = head.kind;
   assign rsp_char_value      = head.ch;
   assign rsp_command_number  = head.cmd;
   assign rsp_argument_number = head.arg;
   assign rsp_line_status     = head.status;
   assign rsp_command_total   = head.total;
   assign rsp_last_of_run     = head.last;

   `CLT_ASSERT_NOW(a_done_is_last, rsp_valid && (head.kind == KIND_DONE), head.last)
   `CLT_ASSERT_NOW(a_nul_makes_done, req_accept && (req_char_code == CHAR_NUL), (push.count == 2'd1) ? (push.first.kind == KIND_DONE) : ((push.count == 2'd2) && (push.second.kind == KIND_DONE)))
   `CLT_ASSERT_NOW(a_empty_never_stalls, !rsp_valid, !req_stall)
   `CLT_ASSERT_NEXT(a_push_shows_valid, push.count != 2'd0, rsp_valid)

endmodule
